[rtl/mcfp_pkg.sv]
`timescale 1ns / 1ps

package mcfp_pkg;

    localparam int HDR_BYTES  = 10;
    localparam int RES_BITS   = 112;

    // register indexes on the configuration port
    localparam logic [2:0] REG_LINK     = 3'd0;
    localparam logic [2:0] REG_TASK     = 3'd1;
    localparam logic [2:0] REG_RESET    = 3'd2;
    localparam logic [2:0] REG_POS_INT  = 3'd3;
    localparam logic [2:0] REG_STATE_INT = 3'd4;
    localparam logic [2:0] REG_ACCEPTED = 3'd5;

    localparam logic [7:0] LINK_CODE_RST     = 8'd128;
    localparam logic [7:0] TASK_CODE_RST     = 8'd129;
    localparam logic [7:0] RESET_CODE_RST    = 8'd130;
    localparam logic [7:0] POS_INT_CODE_RST  = 8'd131;
    localparam logic [7:0] STATE_INT_CODE_RST = 8'd132;
    localparam logic [7:0] ACCEPTED_CODE_RST = 8'd133;

    // result kinds
    localparam logic [1:0] KIND_REPLY    = 2'd0;
    localparam logic [1:0] KIND_HEADER   = 2'd1;
    localparam logic [1:0] KIND_AXIS     = 2'd2;
    localparam logic [1:0] KIND_INTERVAL = 2'd3;

    typedef struct packed {
        logic [7:0] link_code;
        logic [7:0] task_code;
        logic [7:0] reset_code;
        logic [7:0] pos_int_code;
        logic [7:0] state_int_code;
        logic [7:0] accepted_code;
    } t_cfg;

    // packed so that reply_byte sits in the lowest bits
    typedef struct packed {
        logic [2:0]  pad;
        logic [13:0] interval_value;
        logic        interval_select;
        logic [20:0] axis_step;
        logic [2:0]  axis_index;
        logic [15:0] step_rate;
        logic [14:0] decel_steps;
        logic [15:0] total_steps;
        logic [7:0]  dir_bits;
        logic [6:0]  task_id;
        logic [7:0]  reply_byte;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_AXIS,
        ST_ACK,
        ST_ID
    } t_state;

    typedef enum logic [2:0] {
        SEL_SINGLE,
        SEL_HDR,
        SEL_AXIS,
        SEL_ACK,
        SEL_ID
    } t_out_sel;

    typedef struct packed {
        logic     accept;
        logic     load;
        t_out_sel sel;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
        logic single;
        logic issue;
        logic axis_done;
    } t_dp_status;

endpackage

[rtl/mcfp_regs.sv]
`timescale 1ns / 1ps

module mcfp_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output mcfp_pkg::t_cfg o_cfg
);
    import mcfp_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;
    logic [7:0] rd_byte;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.link_code      <= LINK_CODE_RST;
            r_cfg.task_code      <= TASK_CODE_RST;
            r_cfg.reset_code     <= RESET_CODE_RST;
            r_cfg.pos_int_code   <= POS_INT_CODE_RST;
            r_cfg.state_int_code <= STATE_INT_CODE_RST;
            r_cfg.accepted_code  <= ACCEPTED_CODE_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_LINK:      r_cfg.link_code      <= pwdata[7:0];
                REG_TASK:      r_cfg.task_code      <= pwdata[7:0];
                REG_RESET:     r_cfg.reset_code     <= pwdata[7:0];
                REG_POS_INT:   r_cfg.pos_int_code   <= pwdata[7:0];
                REG_STATE_INT: r_cfg.state_int_code <= pwdata[7:0];
                REG_ACCEPTED:  r_cfg.accepted_code  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LINK:      rd_byte = r_cfg.link_code;
            REG_TASK:      rd_byte = r_cfg.task_code;
            REG_RESET:     rd_byte = r_cfg.reset_code;
            REG_POS_INT:   rd_byte = r_cfg.pos_int_code;
            REG_STATE_INT: rd_byte = r_cfg.state_int_code;
            REG_ACCEPTED:  rd_byte = r_cfg.accepted_code;
            default:       rd_byte = 8'd0;
        endcase
    end

    assign prdata = {24'd0, rd_byte};
    assign o_cfg  = r_cfg;

endmodule

[rtl/mcfp_dp.sv]
`timescale 1ns / 1ps

module mcfp_dp #(
    parameter int AXES        = 8,
    parameter int FRAME_DEPTH = 34
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [7:0]             i_rx_byte,
    input  logic                   i_slot_free,
    input  mcfp_pkg::t_cfg         i_cfg,
    input  mcfp_pkg::t_ctrl_cmd    i_cmd,
    output mcfp_pkg::t_dp_status   o_status,
    input  logic                   i_m_ready,
    output logic                   o_m_valid,
    output mcfp_pkg::t_result      o_result,
    output logic [1:0]             o_kind,
    output logic                   o_last
);
    import mcfp_pkg::*;

    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;
    // axis bytes held past the header; later ones read as zero
    localparam logic [6:0] AXIS_KEEP = 7'(FRAME_DEPTH - HDR_BYTES);

    // frame state
    logic [7:0]    r_cur_cmd;
    logic [5:0]    r_rcv;
    logic [5:0]    r_pend;
    logic          r_hdr_done;
    logic [1:0]    r_lane;
    logic [3:0]    r_row;
    logic [6:0]    r_hdr [HDR_BYTES];
    logic [6:0]    r_axb [3][AXES];

    // issue sequencing
    logic [AW-1:0] r_ax;
    logic [AW-1:0] r_k;

    // output register
    logic          r_valid;
    t_result       r_res;
    logic [1:0]    r_kind;
    logic          r_last;

    t_result       n_res;
    logic [1:0]    n_kind;
    logic          n_last;

    logic          is_cmd;
    logic          m_link, m_task, m_pos, m_st;
    logic          c_link, c_task, c_int;
    logic          data_beat, done, go;
    logic [5:0]    pend_dec;
    logic [6:0]    fbv [HDR_BYTES];
    logic [7:0]    en8_now, en8_reg;
    logic [AXES-1:0] en_now, en_reg;
    logic [3:0]    cnt;
    logic [6:0]    kx3;
    logic [6:0]    axb [3];
    logic [20:0]   axis_word;
    t_result       res_single;
    logic [1:0]    kind_single;

    assign is_cmd    = i_rx_byte[7];
    assign m_link    = (i_rx_byte == i_cfg.link_code);
    assign m_task    = (i_rx_byte == i_cfg.task_code);
    assign m_pos     = (i_rx_byte == i_cfg.pos_int_code);
    assign m_st      = (i_rx_byte == i_cfg.state_int_code);
    assign c_link    = (r_cur_cmd == i_cfg.link_code);
    assign c_task    = !c_link && (r_cur_cmd == i_cfg.task_code);
    assign c_int     = !c_link && !c_task &&
                       ((r_cur_cmd == i_cfg.pos_int_code) ||
                        (r_cur_cmd == i_cfg.state_int_code));
    assign data_beat = !is_cmd && (r_pend != 6'd0);
    assign pend_dec  = r_pend - 6'd1;
    assign done      = data_beat && (pend_dec == 6'd0);

    // header as it stands with the current beat included
    always_comb begin
        for (int i = 0; i < HDR_BYTES; i++) begin
            fbv[i] = (r_rcv == 6'(i)) ? i_rx_byte[6:0] : r_hdr[i];
        end
    end

    assign en8_now = {fbv[6][2:0], fbv[7][6:2]};
    assign en_now  = en8_now[AXES-1:0];
    assign en8_reg = {r_hdr[6][2:0], r_hdr[7][6:2]};
    assign en_reg  = en8_reg[AXES-1:0];

    always_comb begin
        cnt = 4'd0;
        for (int i = 0; i < AXES; i++) begin
            cnt = cnt + 4'(en_now[i]);
        end
    end

    assign go = r_hdr_done || (cnt == 4'd0);

    assign o_status.out_free  = !r_valid || i_m_ready;
    assign o_status.single    = (is_cmd && m_link) || (done && c_int);
    assign o_status.issue     = done && c_task && go && i_slot_free;
    assign o_status.axis_done = (r_ax == AW'(AXES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_cmd  <= 8'd0;
            r_rcv      <= 6'd0;
            r_pend     <= 6'd0;
            r_hdr_done <= 1'b0;
            r_lane     <= 2'd0;
            r_row      <= 4'd0;
        end else if (i_cmd.accept) begin
            if (is_cmd) begin
                r_cur_cmd  <= i_rx_byte;
                r_rcv      <= 6'd0;
                r_hdr_done <= 1'b0;
                r_lane     <= 2'd0;
                r_row      <= 4'd0;
                priority if (m_link)        r_pend <= 6'd0;
                else if (m_task)            r_pend <= 6'(HDR_BYTES);
                else if (m_pos || m_st)     r_pend <= 6'd2;
                else                        r_pend <= 6'd0;
            end else if (data_beat) begin
                r_rcv  <= r_rcv + 6'd1;
                if (r_rcv >= 6'(HDR_BYTES)) begin
                    if (r_lane == 2'd2) begin
                        r_lane <= 2'd0;
                        r_row  <= r_row + 4'd1;
                    end else begin
                        r_lane <= r_lane + 2'd1;
                    end
                end
                if (done && c_task) begin
                    r_hdr_done <= !go;
                end
                // a finished header reloads the count with the axis bytes
                if (done && c_task && !r_hdr_done) begin
                    r_pend <= 6'(cnt) * 6'd3;
                end else begin
                    r_pend <= pend_dec;
                end
            end
        end
    end

    // frame storage; bytes past the axis rows are never read back
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && data_beat) begin
            if (r_rcv < 6'(HDR_BYTES)) begin
                r_hdr[r_rcv[3:0]] <= i_rx_byte[6:0];
            end else if (r_row < 4'(AXES)) begin
                r_axb[r_lane][r_row[AW-1:0]] <= i_rx_byte[6:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= '0;
            r_k  <= '0;
        end else if (i_cmd.load) begin
            if (i_cmd.sel == SEL_HDR) begin
                r_ax <= '0;
                r_k  <= '0;
            end else if (i_cmd.sel == SEL_AXIS) begin
                r_ax <= r_ax + AW'(1);
                r_k  <= r_k + AW'(en_reg[r_ax]);
            end
        end
    end

    assign kx3 = 7'(r_k) * 7'd3;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            axb[l] = ((kx3 + 7'(l)) < AXIS_KEEP) ? r_axb[l][r_k] : 7'd0;
        end
    end

    assign axis_word = {axb[0], axb[1], axb[2]};

    always_comb begin
        res_single  = '0;
        kind_single = KIND_REPLY;
        if (is_cmd) begin
            res_single.reply_byte = i_cfg.link_code;
        end else begin
            kind_single                = KIND_INTERVAL;
            res_single.interval_select = (r_cur_cmd != i_cfg.pos_int_code);
            res_single.interval_value  = {fbv[0], fbv[1]};
        end
    end

    always_comb begin
        n_res  = '0;
        n_kind = KIND_REPLY;
        n_last = 1'b0;
        unique case (i_cmd.sel)
            SEL_SINGLE: begin
                n_res  = res_single;
                n_kind = kind_single;
                n_last = 1'b1;
            end
            SEL_HDR: begin
                n_kind            = KIND_HEADER;
                n_res.task_id     = r_hdr[0];
                n_res.dir_bits    = {r_hdr[1], r_hdr[2][6]};
                n_res.total_steps = {r_hdr[2][5:0], r_hdr[3], r_hdr[4][6:4]};
                n_res.decel_steps = {r_hdr[4][3:0], r_hdr[5], r_hdr[6][6:3]};
                n_res.step_rate   = {r_hdr[7][1:0], r_hdr[8], r_hdr[9]};
            end
            SEL_AXIS: begin
                n_kind           = KIND_AXIS;
                n_res.axis_index = 3'(r_ax);
                n_res.axis_step  = en_reg[r_ax] ? axis_word : 21'd0;
            end
            SEL_ACK: begin
                n_res.reply_byte = i_cfg.accepted_code;
            end
            SEL_ID: begin
                n_res.reply_byte = {1'b0, r_hdr[0]};
                n_last           = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res  <= n_res;
            r_kind <= n_kind;
            r_last <= n_last;
        end
    end

    assign o_m_valid = r_valid;
    assign o_result  = r_res;
    assign o_kind    = r_kind;
    assign o_last    = r_last;

endmodule

[rtl/mcfp_ctrl.sv]
`timescale 1ns / 1ps

module mcfp_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_valid,
    output logic                  o_s_ready,
    input  mcfp_pkg::t_dp_status  i_status,
    output mcfp_pkg::t_ctrl_cmd   o_cmd
);
    import mcfp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_s_ready    = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.sel    = SEL_SINGLE;
        unique case (r_state)
            ST_IDLE: begin
                // a single result goes straight into the output register
                o_s_ready    = i_status.out_free;
                o_cmd.accept = i_s_valid && i_status.out_free;
                if (o_cmd.accept) begin
                    o_cmd.load = i_status.single;
                    if (i_status.issue) begin
                        n_state = ST_HDR;
                    end
                end
            end
            ST_HDR: begin
                o_cmd.sel = SEL_HDR;
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_AXIS;
                end
            end
            ST_AXIS: begin
                o_cmd.sel = SEL_AXIS;
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    if (i_status.axis_done) begin
                        n_state = ST_ACK;
                    end
                end
            end
            ST_ACK: begin
                o_cmd.sel = SEL_ACK;
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_ID;
                end
            end
            ST_ID: begin
                o_cmd.sel = SEL_ID;
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_issue_starts_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_status.issue) |=> (r_state == ST_HDR))
        else $error("task issue did not start the header beat");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> i_status.out_free)
        else $error("output register overwritten");

    a_axis_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_AXIS && !(o_cmd.load && i_status.axis_done))
        |=> (r_state == ST_AXIS))
        else $error("axis sequence left early");

    a_id_ends_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ID && o_cmd.load) |=> (r_state == ST_IDLE && !$past(o_cmd.accept)))
        else $error("task sequence did not end after the id reply");

endmodule

[rtl/motion_command_frame_parser.sv]
`timescale 1ns / 1ps
// Motion command frame parser.
// s_axis: one received serial byte per beat, tdata = rx_byte, tuser = slot_free
// (sampled on the byte that completes a task frame).
// m_axis: result beats; tuser = kind, tlast marks the final result of a byte.
// APB: six 8-bit code registers at byte addresses 0x00..0x14, pready tied high.
// A single result is registered into the output register as its byte is accepted.
// Throughput: bytes that give at most one result are taken one per cycle while
// the output register is free. A byte that issues a task emits AXES+3 results,
// one per cycle while the output register is free, from the header, axis and
// reply sequencer; s_axis_tready stays low until the last of them is loaded,
// so such a byte holds the input for its own accepting cycle and one load per result.
// The single output register sets the stall behaviour: when m_axis_tready is
// low with a result waiting, the sequencer and s_axis_tready hold until it goes.
// Reset (synchronous, active low) clears the frame counters, the command
// latch and the output valid and loads the default codes. Frame storage is
// not cleared and needs no clearing pass.
module motion_command_frame_parser #(
    parameter int AXES        = 8,
    parameter int FRAME_DEPTH = 34
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // [7:0] rx_byte
    input  logic          s_axis_tuser,   // [0] slot_free
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [7:0] reply_byte, [14:8] task_id, [22:15] dir_bits, [38:23] total_steps,
    // [53:39] decel_steps, [69:54] step_rate, [72:70] axis_index,
    // [93:73] axis_step, [94] interval_select, [108:95] interval_value, rest 0
    output logic [mcfp_pkg::RES_BITS-1:0] m_axis_tdata,
    output logic [1:0]    m_axis_tuser,   // [1:0] kind
    output logic          m_axis_tlast,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import mcfp_pkg::*;

    t_cfg       cfg;
    t_ctrl_cmd  cmd;
    t_dp_status status;
    t_result    res;

    mcfp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mcfp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    mcfp_dp #(
        .AXES        (AXES),
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_byte   (s_axis_tdata),
        .i_slot_free (s_axis_tuser),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_result    (res),
        .o_kind      (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = res;

endmodule
